@@ hdl/thqu_pkg.sv @@
// shared types and constants for the trust hysteresis quarantine unit
package thqu_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int TRUST_W      = 17;
    localparam int GAIN_W       = 20;
    localparam int TIME_W       = 32;
    localparam int QCNT_W       = 9;
    localparam int NODE_IDX_W   = 8;
    localparam int IDX_SPAN     = 1 << NODE_IDX_W;
    localparam int PROD_W       = GAIN_W + TRUST_W;
    localparam int DELTA_W      = PROD_W + 1;
    localparam int STEP_W       = DELTA_W - FRAC_BITS;
    localparam int SUM_W        = STEP_W + 1;
    localparam int CFG_ADDR_W   = 5;
    localparam int CFG_DATA_W   = 32;

    localparam logic [TRUST_W-1:0] ONE_Q    = TRUST_W'(1) << FRAC_BITS;
    localparam logic [QCNT_W-1:0]  QCNT_MAX = '1;

    typedef enum logic [2:0] {
        REG_ALPHA_GAIN   = 3'd0,
        REG_BETA_GAIN    = 3'd1,
        REG_QUAR_THRESH  = 3'd2,
        REG_REIN_THRESH  = 3'd3,
        REG_DWELL_WINDOW = 3'd4,
        REG_MITIG_ENABLE = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        TR_NONE      = 2'd0,
        TR_ENTER     = 2'd1,
        TR_REINSTATE = 2'd2
    } transition_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_APPLY   = 2'd1,
        ACT_RESTORE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  alpha_gain;
        logic [GAIN_W-1:0]  beta_gain;
        logic [TRUST_W-1:0] quarantine_threshold;
        logic [TRUST_W-1:0] reinstate_threshold;
        logic [TIME_W-1:0]  dwell_window;
        logic               mitigation_enable;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
    } dp_cmd_t;

    typedef struct packed {
        logic [TRUST_W-1:0] trust;
        logic [TIME_W-1:0]  low_since_time;
        logic               low_since_valid;
        logic               isolated;
    } node_entry_t;

endpackage

@@ hdl/trust_hysteresis_quarantine_unit.sv @@
// top level of the trust hysteresis quarantine unit
// each transaction runs in order through table read, multiply and update; a new
// transaction is accepted only once the previous one has finished its update,
// and the update, which registers the result, waits while the previous result waits for m_ready
// reset: synchronous active-low aresetn clears all seen flags, round stats and
// control and config registers at once; no clearing pass, inputs are accepted right after reset
module trust_hysteresis_quarantine_unit #(
    parameter int NODE_COUNT = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [thqu_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [thqu_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [thqu_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [thqu_pkg::NODE_IDX_W-1:0]    s_node_index,
    input  logic                               s_first_in_round,
    input  logic [thqu_pkg::TIME_W-1:0]        s_now_time,
    input  logic [thqu_pkg::TRUST_W-1:0]       s_observed_belief,
    input  logic [thqu_pkg::TRUST_W-1:0]       s_detector_belief,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [thqu_pkg::TRUST_W-1:0]       m_trust_value,
    output logic                               m_is_quarantined,
    output logic [1:0]                         m_transition,
    output logic [1:0]                         m_mitigation_action,
    output logic [thqu_pkg::TRUST_W-1:0]       m_round_min_trust,
    output logic [thqu_pkg::QCNT_W-1:0]        m_round_quarantined
);
    import thqu_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;

    assign pready = 1'b1;

    thqu_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    thqu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    thqu_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg),
        .cmd                 (cmd),
        .s_node_index        (s_node_index),
        .s_first_in_round    (s_first_in_round),
        .s_now_time          (s_now_time),
        .s_observed_belief   (s_observed_belief),
        .s_detector_belief   (s_detector_belief),
        .m_trust_value       (m_trust_value),
        .m_is_quarantined    (m_is_quarantined),
        .m_transition        (m_transition),
        .m_mitigation_action (m_mitigation_action),
        .m_round_min_trust   (m_round_min_trust),
        .m_round_quarantined (m_round_quarantined)
    );

endmodule

@@ hdl/thqu_cfg.sv @@
// apb register file holding gains, thresholds, dwell window and mitigation enable
module thqu_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [thqu_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [thqu_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [thqu_pkg::CFG_DATA_W-1:0]   prdata,
    output thqu_pkg::cfg_t                    cfg
);
    import thqu_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_ALPHA_GAIN:   cfg_next.alpha_gain           = pwdata[GAIN_W-1:0];
                REG_BETA_GAIN:    cfg_next.beta_gain            = pwdata[GAIN_W-1:0];
                REG_QUAR_THRESH:  cfg_next.quarantine_threshold = pwdata[TRUST_W-1:0];
                REG_REIN_THRESH:  cfg_next.reinstate_threshold  = pwdata[TRUST_W-1:0];
                REG_DWELL_WINDOW: cfg_next.dwell_window         = pwdata[TIME_W-1:0];
                REG_MITIG_ENABLE: cfg_next.mitigation_enable    = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha_gain           <= '0;
            cfg_reg.beta_gain            <= '0;
            cfg_reg.quarantine_threshold <= '0;
            cfg_reg.reinstate_threshold  <= ONE_Q;
            cfg_reg.dwell_window         <= '0;
            cfg_reg.mitigation_enable    <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ALPHA_GAIN:   prdata = CFG_DATA_W'(cfg_reg.alpha_gain);
            REG_BETA_GAIN:    prdata = CFG_DATA_W'(cfg_reg.beta_gain);
            REG_QUAR_THRESH:  prdata = CFG_DATA_W'(cfg_reg.quarantine_threshold);
            REG_REIN_THRESH:  prdata = CFG_DATA_W'(cfg_reg.reinstate_threshold);
            REG_DWELL_WINDOW: prdata = CFG_DATA_W'(cfg_reg.dwell_window);
            REG_MITIG_ENABLE: prdata = CFG_DATA_W'(cfg_reg.mitigation_enable);
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/thqu_ctrl.sv @@
// controller state machine sequencing read, multiply and update of one transaction
module thqu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output thqu_pkg::dp_cmd_t cmd
);
    import thqu_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid)  state_next = ST_MUL;
            ST_MUL:                state_next = ST_UPD;
            ST_UPD:  if (out_free) state_next = ST_IDLE;
            default:               state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
            end
            ST_UPD: begin
                cmd.upd = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
        priority if (cmd.upd) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ hdl/thqu_datapath.sv @@
// node table, trust update arithmetic, quarantine hysteresis and round statistics
module thqu_datapath #(
    parameter int NODE_COUNT = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  thqu_pkg::cfg_t                     cfg,
    input  thqu_pkg::dp_cmd_t                  cmd,
    input  logic [thqu_pkg::NODE_IDX_W-1:0]    s_node_index,
    input  logic                               s_first_in_round,
    input  logic [thqu_pkg::TIME_W-1:0]        s_now_time,
    input  logic [thqu_pkg::TRUST_W-1:0]       s_observed_belief,
    input  logic [thqu_pkg::TRUST_W-1:0]       s_detector_belief,
    output logic [thqu_pkg::TRUST_W-1:0]       m_trust_value,
    output logic                               m_is_quarantined,
    output logic [1:0]                         m_transition,
    output logic [1:0]                         m_mitigation_action,
    output logic [thqu_pkg::TRUST_W-1:0]       m_round_min_trust,
    output logic [thqu_pkg::QCNT_W-1:0]        m_round_quarantined
);
    import thqu_pkg::*;

    localparam int DEPTH = (NODE_COUNT < IDX_SPAN) ? NODE_COUNT : IDX_SPAN;
    localparam int IDX_W = $clog2(DEPTH);

    // node index folded into the table
    logic [IDX_W-1:0] idx_map [IDX_SPAN];
    for (genvar g = 0; g < IDX_SPAN; g++) begin : g_idx_map
        assign idx_map[g] = IDX_W'(g % NODE_COUNT);
    end

    node_entry_t mem [DEPTH];
    node_entry_t rd_reg;
    logic [DEPTH-1:0] seen_reg;

    logic [IDX_W-1:0]   idx_reg;
    logic               first_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [TRUST_W-1:0] belief_reg;
    logic [TRUST_W-1:0] belief_next;
    logic [TRUST_W-1:0] belief_raw;

    // multiply stage
    logic [TRUST_W-1:0] trust_cur_reg;
    logic [TRUST_W-1:0] trust_cur_next;
    logic               lv_cur_reg;
    logic               lv_cur_next;
    logic [TIME_W-1:0]  lt_cur_reg;
    logic [TIME_W-1:0]  lt_cur_next;
    logic               iso_cur_reg;
    logic               iso_cur_next;
    logic [TRUST_W-1:0] trust_gap;
    logic [PROD_W-1:0]  p_beta_reg;
    logic [PROD_W-1:0]  p_beta_next;
    logic [PROD_W-1:0]  p_alpha_reg;
    logic [PROD_W-1:0]  p_alpha_next;

    // update stage
    logic signed [DELTA_W-1:0] delta;
    logic signed [STEP_W-1:0]  step;
    logic signed [SUM_W-1:0]   trust_sum;
    logic [TRUST_W-1:0]        trust_new;
    logic                      lv_new;
    logic [TIME_W-1:0]         lt_new;
    logic                      iso_new;
    logic [TIME_W-1:0]         elapsed;
    transition_t               trans_new;
    action_t                   act_new;
    action_t                   act_apply;
    logic [QCNT_W-1:0]         qacc_base;
    logic [QCNT_W-1:0]         qacc_next;
    logic [TRUST_W-1:0]        min_base;
    logic [TRUST_W-1:0]        min_next;
    logic [QCNT_W-1:0]         qacc_reg;
    logic [TRUST_W-1:0]        min_reg;

    logic [TRUST_W-1:0] out_trust_reg;
    logic               out_iso_reg;
    transition_t        out_trans_reg;
    action_t            out_act_reg;

    always_comb begin
        if (s_observed_belief == '0) begin
            belief_raw = '0;
        end else if (s_observed_belief > s_detector_belief) begin
            belief_raw = s_observed_belief;
        end else begin
            belief_raw = s_detector_belief;
        end
        belief_next = (belief_raw > ONE_Q) ? ONE_Q : belief_raw;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            idx_reg    <= idx_map[s_node_index];
            first_reg  <= s_first_in_round;
            now_reg    <= s_now_time;
            belief_reg <= belief_next;
            rd_reg     <= mem[idx_map[s_node_index]];
        end
    end

    always_comb begin
        if (seen_reg[idx_reg]) begin
            trust_cur_next = rd_reg.trust;
            lv_cur_next    = rd_reg.low_since_valid;
            lt_cur_next    = rd_reg.low_since_time;
            iso_cur_next   = rd_reg.isolated;
        end else begin
            trust_cur_next = ONE_Q;
            lv_cur_next    = 1'b0;
            lt_cur_next    = '0;
            iso_cur_next   = 1'b0;
        end
        trust_gap    = ONE_Q - trust_cur_next;
        p_beta_next  = PROD_W'(cfg.beta_gain) * PROD_W'(trust_gap);
        p_alpha_next = PROD_W'(cfg.alpha_gain) * PROD_W'(belief_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            trust_cur_reg <= trust_cur_next;
            lv_cur_reg    <= lv_cur_next;
            lt_cur_reg    <= lt_cur_next;
            iso_cur_reg   <= iso_cur_next;
            p_beta_reg    <= p_beta_next;
            p_alpha_reg   <= p_alpha_next;
        end
    end

    always_comb begin
        delta     = $signed({1'b0, p_beta_reg}) - $signed({1'b0, p_alpha_reg});
        // arithmetic shift rounds toward minus infinity
        step      = STEP_W'(delta >>> FRAC_BITS);
        trust_sum = $signed({{(SUM_W - TRUST_W){1'b0}}, trust_cur_reg})
                  + $signed({step[STEP_W-1], step});
        priority if (trust_sum < 0) begin
            trust_new = '0;
        end else if (trust_sum > $signed(SUM_W'(ONE_Q))) begin
            trust_new = ONE_Q;
        end else begin
            trust_new = trust_sum[TRUST_W-1:0];
        end

        lv_new = lv_cur_reg;
        lt_new = lt_cur_reg;
        if (trust_new < cfg.quarantine_threshold) begin
            if (!lv_cur_reg) begin
                lv_new = 1'b1;
                lt_new = now_reg;
            end
        end else begin
            lv_new = 1'b0;
        end

        elapsed   = now_reg - lt_new;
        act_apply = cfg.mitigation_enable ? ACT_APPLY : ACT_NONE;
        iso_new   = iso_cur_reg;
        trans_new = TR_NONE;
        act_new   = ACT_NONE;
        priority if (!iso_cur_reg) begin
            if (lv_new && (elapsed >= cfg.dwell_window)) begin
                iso_new   = 1'b1;
                trans_new = TR_ENTER;
                act_new   = act_apply;
            end
        end else if (trust_new >= cfg.reinstate_threshold) begin
            iso_new   = 1'b0;
            lv_new    = 1'b0;
            trans_new = TR_REINSTATE;
            act_new   = ACT_RESTORE;
        end else begin
            act_new   = act_apply;
        end

        qacc_base = first_reg ? '0 : qacc_reg;
        min_base  = first_reg ? ONE_Q : min_reg;
        qacc_next = (iso_new && (qacc_base != QCNT_MAX)) ? qacc_base + 1'b1 : qacc_base;
        min_next  = (trust_new < min_base) ? trust_new : min_base;
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            mem[idx_reg] <= '{trust:           trust_new,
                              low_since_time:  lt_new,
                              low_since_valid: lv_new,
                              isolated:        iso_new};
            out_trust_reg <= trust_new;
            out_iso_reg   <= iso_new;
            out_trans_reg <= trans_new;
            out_act_reg   <= act_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            qacc_reg <= '0;
            min_reg  <= ONE_Q;
        end else if (cmd.upd) begin
            seen_reg[idx_reg] <= 1'b1;
            qacc_reg          <= qacc_next;
            min_reg           <= min_next;
        end
    end

    assign m_trust_value       = out_trust_reg;
    assign m_is_quarantined    = out_iso_reg;
    assign m_transition        = out_trans_reg;
    assign m_mitigation_action = out_act_reg;
    assign m_round_min_trust   = min_reg;
    assign m_round_quarantined = qacc_reg;

endmodule
